// ===== hw/rtl/udw_pkg.sv =====
// Shared types, constants and the column width function of the UTF-8 width decoder.
package udw_pkg;

  localparam int CP_BITS = 21;

  localparam logic [CP_BITS-1:0] REPL_CP = 21'h00FFFD;

  // Kind of the result that closes a byte's beats, after any flushed bytes.
  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_POINT,
    TAIL_END
  } udw_tail_t;

  // Work that one accepted byte leaves for the result side.
  typedef struct packed {
    logic [1:0]         flush;
    udw_tail_t          tail;
    logic [CP_BITS-1:0] tail_cp;
    logic               tail_rep;
    logic [1:0]         tail_width;
  } udw_plan_t;

  localparam int ZERO_N = 13;
  localparam int WIDE_N = 15;

  localparam logic [CP_BITS-1:0] ZERO_LO [ZERO_N] = '{
    21'h0300, 21'h0483, 21'h0591, 21'h0610, 21'h064B, 21'h0E31, 21'h1AB0,
    21'h1DC0, 21'h200B, 21'h20D0, 21'hFE00, 21'hFE20, 21'hFEFF
  };
  localparam logic [CP_BITS-1:0] ZERO_HI [ZERO_N] = '{
    21'h036F, 21'h0489, 21'h05BD, 21'h061A, 21'h065F, 21'h0E3A, 21'h1AFF,
    21'h1DFF, 21'h200D, 21'h20F0, 21'hFE0F, 21'hFE2F, 21'hFEFF
  };

  localparam logic [CP_BITS-1:0] WIDE_LO [WIDE_N] = '{
    21'h01100, 21'h02E80, 21'h03041, 21'h03400, 21'h04E00, 21'h0A000,
    21'h0AC00, 21'h0F900, 21'h0FE30, 21'h0FF00, 21'h0FFE0, 21'h1F300,
    21'h1F680, 21'h1F900, 21'h20000
  };
  localparam logic [CP_BITS-1:0] WIDE_HI [WIDE_N] = '{
    21'h0115F, 21'h0303E, 21'h033FF, 21'h04DBF, 21'h09FFF, 21'h0A4CF,
    21'h0D7A3, 21'h0FAFF, 21'h0FE6F, 21'h0FF60, 21'h0FFE6, 21'h1F64F,
    21'h1F6FF, 21'h1F9FF, 21'h3FFFD
  };

  // Terminal columns of a code point: zero-width spans win over wide spans.
  function automatic logic [1:0] cp_columns(input logic [CP_BITS-1:0] cp);
    logic zero_hit;
    logic wide_hit;
    zero_hit = (cp < 21'h20) || ((cp >= 21'h7F) && (cp < 21'hA0));
    wide_hit = 1'b0;
    for (int i = 0; i < ZERO_N; i++) begin
      if ((cp >= ZERO_LO[i]) && (cp <= ZERO_HI[i])) zero_hit = 1'b1;
    end
    for (int j = 0; j < WIDE_N; j++) begin
      if ((cp >= WIDE_LO[j]) && (cp <= WIDE_HI[j])) wide_hit = 1'b1;
    end
    if (zero_hit) return 2'd0;
    if (wide_hit) return 2'd2;
    return 2'd1;
  endfunction

endpackage

// ===== hw/rtl/udw_decode.sv =====
// Byte-level UTF-8 sequence tracker that turns each accepted byte into a result plan.
module udw_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        text_byte,
  output udw_pkg::udw_plan_t plan
);
  import udw_pkg::*;

  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_TAG  = 8'hF0;

  logic [CP_BITS-1:0] partial_r, partial_nxt;
  logic [1:0]         needed_r, needed_nxt;
  logic [1:0]         taken_r, taken_nxt;
  logic [CP_BITS-1:0] joined;
  logic               fresh;

  assign joined = {partial_r[CP_BITS-7:0], text_byte[5:0]};

  always_comb begin
    partial_nxt     = partial_r;
    needed_nxt      = needed_r;
    taken_nxt       = taken_r;
    fresh           = 1'b1;
    plan.flush      = 2'd0;
    plan.tail       = TAIL_NONE;
    plan.tail_cp    = '0;
    plan.tail_rep   = 1'b0;

    if (needed_r != 2'd0) begin
      if ((text_byte & CONT_MASK) == CONT_TAG) begin
        fresh       = 1'b0;
        partial_nxt = joined;
        needed_nxt  = needed_r - 2'd1;
        taken_nxt   = taken_r + 2'd1;
        if (needed_r == 2'd1) begin
          plan.tail    = TAIL_POINT;
          plan.tail_cp = joined;
          partial_nxt  = '0;
          taken_nxt    = 2'd0;
        end
      end else begin
        // broken sequence: flush what was held, then decode this byte afresh
        plan.flush  = taken_r;
        partial_nxt = '0;
        needed_nxt  = 2'd0;
        taken_nxt   = 2'd0;
      end
    end

    if (fresh) begin
      if (text_byte == 8'h00) begin
        plan.tail = TAIL_END;
      end else if (!text_byte[7]) begin
        plan.tail    = TAIL_POINT;
        plan.tail_cp = {{(CP_BITS-8){1'b0}}, text_byte};
      end else if ((text_byte & LEAD2_MASK) == LEAD2_TAG) begin
        partial_nxt = {{(CP_BITS-5){1'b0}}, text_byte[4:0]};
        needed_nxt  = 2'd1;
        taken_nxt   = 2'd1;
      end else if ((text_byte & LEAD3_MASK) == LEAD3_TAG) begin
        partial_nxt = {{(CP_BITS-4){1'b0}}, text_byte[3:0]};
        needed_nxt  = 2'd2;
        taken_nxt   = 2'd1;
      end else if ((text_byte & LEAD4_MASK) == LEAD4_TAG) begin
        partial_nxt = {{(CP_BITS-3){1'b0}}, text_byte[2:0]};
        needed_nxt  = 2'd3;
        taken_nxt   = 2'd1;
      end else begin
        plan.tail     = TAIL_POINT;
        plan.tail_cp  = REPL_CP;
        plan.tail_rep = 1'b1;
      end
    end

    plan.tail_width = cp_columns(plan.tail_cp);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      needed_r  <= 2'd0;
      taken_r   <= 2'd0;
    end else if (fire) begin
      partial_r <= partial_nxt;
      needed_r  <= needed_nxt;
      taken_r   <= taken_nxt;
    end
  end

endmodule

// ===== hw/rtl/utf8_decode_display_width.sv =====
// Top level of the streaming UTF-8 decoder with terminal column width and text totals.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------------
//   in_     | input     | in_valid / in_ready  | in_text_byte
//   out_    | output    | out_valid / out_ready| code_point, column_width, is_replacement,
//           |           |                      | total_width, point_count, end_of_text,
//           |           |                      | last_result
//
// A byte that yields one result, or none, is taken every cycle while out_ready holds; a
// byte with more results holds the input side until its last beat is sent, since the
// result register sends one beat per cycle. A byte passes the plan, then the result register.
// Reset (rst_n low, synchronous) clears the sequence state, the plan and the totals.
// A stalled out_ready holds the result register; the plan register still takes one
// more byte, so the input stops only once both are full.
module utf8_decode_display_width #(
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] out_code_point,
  output logic [1:0]  out_column_width,
  output logic        out_is_replacement,
  output logic [31:0] out_total_width,
  output logic [31:0] out_point_count,
  output logic        out_end_of_text,
  output logic        out_last_result
);
  import udw_pkg::*;

  // Decoder: sequence state and the plan of result beats for each byte.
  udw_plan_t dec_plan;
  logic      in_fire;

  udw_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .text_byte (in_text_byte),
    .plan      (dec_plan)
  );

  // Plan register: flushed replacement bytes first, then the tail result.
  udw_plan_t plan_r, plan_nxt;
  logic      plan_busy;
  logic      plan_last;
  logic      emit_fire;

  assign plan_busy = (plan_r.flush != 2'd0) || (plan_r.tail != TAIL_NONE);
  assign plan_last = ((plan_r.flush == 2'd1) && (plan_r.tail == TAIL_NONE)) ||
                     ((plan_r.flush == 2'd0) && (plan_r.tail != TAIL_NONE));

  // Emit one beat whenever the result register is free or being drained.
  assign emit_fire = plan_busy && (!out_valid || out_ready);
  assign in_ready  = !plan_busy || (plan_last && emit_fire);
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    plan_nxt = plan_r;
    if (in_fire) begin
      plan_nxt = dec_plan;
    end else if (emit_fire) begin
      if (plan_r.flush != 2'd0) plan_nxt.flush = plan_r.flush - 2'd1;
      else                      plan_nxt.tail  = TAIL_NONE;
    end
  end

  // Clear the whole plan on reset; an empty plan has no flush and no tail.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plan_r <= '0;
    end else begin
      plan_r <= plan_nxt;
    end
  end

  // Current beat taken from the plan.
  logic [CP_BITS-1:0] e_cp;
  logic [1:0]         e_width;
  logic               e_rep;
  logic               e_end;
  logic               e_last;

  always_comb begin
    if (plan_r.flush != 2'd0) begin
      e_cp    = REPL_CP;
      e_width = 2'd1;
      e_rep   = 1'b1;
      e_end   = 1'b0;
      e_last  = (plan_r.flush == 2'd1) && (plan_r.tail == TAIL_NONE);
    end else begin
      e_cp    = plan_r.tail_cp;
      e_width = plan_r.tail_width;
      e_rep   = plan_r.tail_rep;
      e_end   = (plan_r.tail == TAIL_END);
      e_last  = 1'b1;
    end
  end

  // Running totals, saturating at all ones; the end beat shows them and clears them.
  logic [COUNT_BITS-1:0] width_sum_r, width_sum_nxt;
  logic [COUNT_BITS-1:0] point_total_r, point_total_nxt;
  logic [COUNT_BITS:0]   width_add;
  logic [COUNT_BITS:0]   point_add;
  logic [COUNT_BITS-1:0] width_sat;
  logic [COUNT_BITS-1:0] point_sat;
  logic [COUNT_BITS-1:0] shown_width;
  logic [COUNT_BITS-1:0] shown_points;
  logic [31:0]           shown_width_lo;
  logic [31:0]           shown_points_lo;

  assign width_add = {1'b0, width_sum_r} + {{(COUNT_BITS-1){1'b0}}, e_width};
  assign point_add = {1'b0, point_total_r} + {{COUNT_BITS{1'b0}}, 1'b1};
  assign width_sat = width_add[COUNT_BITS] ? {COUNT_BITS{1'b1}} : width_add[COUNT_BITS-1:0];
  assign point_sat = point_add[COUNT_BITS] ? {COUNT_BITS{1'b1}} : point_add[COUNT_BITS-1:0];

  always_comb begin
    if (e_end) begin
      shown_width     = width_sum_r;
      shown_points    = point_total_r;
      width_sum_nxt   = '0;
      point_total_nxt = '0;
    end else begin
      shown_width     = width_sat;
      shown_points    = point_sat;
      width_sum_nxt   = width_sat;
      point_total_nxt = point_sat;
    end
  end

  // Show the low 32 bits of the totals; zero-extend narrow counters.
  generate
    if (COUNT_BITS >= 32) begin : g_wide_count
      assign shown_width_lo  = shown_width[31:0];
      assign shown_points_lo = shown_points[31:0];
    end else begin : g_narrow_count
      assign shown_width_lo  = {{(32-COUNT_BITS){1'b0}}, shown_width};
      assign shown_points_lo = {{(32-COUNT_BITS){1'b0}}, shown_points};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_sum_r   <= '0;
      point_total_r <= '0;
    end else if (emit_fire) begin
      width_sum_r   <= width_sum_nxt;
      point_total_r <= point_total_nxt;
    end
  end

  // Result register: advance on each emitted beat, drop valid once taken.
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  logic [20:0] out_code_point_r;
  logic [1:0]  out_column_width_r;
  logic        out_is_replacement_r;
  logic [31:0] out_total_width_r;
  logic [31:0] out_point_count_r;
  logic        out_end_of_text_r;
  logic        out_last_result_r;

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_code_point_r     <= e_cp;
      out_column_width_r   <= e_width;
      out_is_replacement_r <= e_rep;
      out_total_width_r    <= shown_width_lo;
      out_point_count_r    <= shown_points_lo;
      out_end_of_text_r    <= e_end;
      out_last_result_r    <= e_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_code_point     = out_code_point_r;
  assign out_column_width   = out_column_width_r;
  assign out_is_replacement = out_is_replacement_r;
  assign out_total_width    = out_total_width_r;
  assign out_point_count    = out_point_count_r;
  assign out_end_of_text    = out_end_of_text_r;
  assign out_last_result    = out_last_result_r;

endmodule

// ===== hw/rtl/udw_checker.sv =====
// Port-level checker for the UTF-8 width decoder and its bind to the top level.
module udw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [20:0] out_code_point,
  input logic [1:0]  out_column_width,
  input logic        out_is_replacement,
  input logic [31:0] out_total_width,
  input logic [31:0] out_point_count,
  input logic        out_end_of_text,
  input logic        out_last_result
);

  // A stalled result beat stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // The end beat closes its byte and carries no code point.
  a_end_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_text |->
      out_last_result && (out_code_point == 21'd0) && (out_column_width == 2'd0) &&
      !out_is_replacement)
    else $error("malformed end-of-text beat");

  // A replacement is always U+FFFD of one column.
  a_repl_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_replacement |->
      (out_code_point == 21'h00FFFD) && (out_column_width == 2'd1))
    else $error("malformed replacement beat");

  // A beat after a taken end beat starts a fresh text.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_end_of_text ##1 out_valid |->
      (out_point_count <= 32'd1) && (out_total_width <= 32'd2))
    else $error("totals not cleared after end of text");

endmodule

bind utf8_decode_display_width udw_checker u_udw_checker (.*);
